// File: src/sra_pkg.sv
// shared types and constants for the skyline rectangle allocator
`timescale 1ns / 1ps
package sra_pkg;

   localparam int CB           = 13;
   localparam int USED_W       = 25;
   localparam int MAX_SEG_DEF  = 64;
   localparam int REQ_DATA_W   = 32;
   localparam int RSP_DATA_W   = 56;

   localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};

   // operation codes
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_PROBE = 2'd1;
   localparam logic [1:0] OP_GROW  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOFIT  = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_SHRINK = 2'd3;

   // register indexes
   localparam logic REG_INIT_WIDTH  = 1'b0;
   localparam logic REG_INIT_HEIGHT = 1'b1;

   typedef struct packed {
      logic [CB-1:0] len;
      logic [CB-1:0] top;
      logic [CB-1:0] x;
   } seg_type;

endpackage

// File: src/sra_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module sra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/skyline_rect_allocator_unit.sv
// top level of the skyline rectangle allocator
`timescale 1ns / 1ps
// grow and clear: the start state, then the done state raises the result beat
// allocate and probe: each fit scan segment read is a read state then a use state
// (each start segment walks the span it covers), so up to about n*n reads for n segments
// allocate then rewrites the list in a read and a use state per old segment, one ram read each
// one item at a time; the next beat is taken once the result is registered
// synchronous active high reset: empty store, zero area, init registers 1024
module skyline_rect_allocator_unit #(
   parameter int MAX_SEGMENTS = sra_pkg::MAX_SEG_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sra_pkg::REQ_DATA_W-1:0] req_tdata,  // width, height
   input  logic [1:0]                    req_tuser,  // op
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sra_pkg::RSP_DATA_W-1:0] rsp_tdata, // ok, status, pos_x, pos_y, used_area
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [sra_pkg::CB-1:0]        csr_wdata
);

   localparam int CB = sra_pkg::CB;
   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int RAM_DEPTH = 1 << (IW + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

   // state codes
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_START  = 4'd1;
   localparam logic [3:0] S_FRD    = 4'd2;
   localparam logic [3:0] S_FUSE   = 4'd3;
   localparam logic [3:0] S_DECIDE = 4'd4;
   localparam logic [3:0] S_WRD    = 4'd5;
   localparam logic [3:0] S_WUSE   = 4'd6;
   localparam logic [3:0] S_FLUSH  = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   // control registers
   logic [3:0]  state_ff, state_in;
   logic        bank_ff, bank_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CB-1:0] aw_ff, aw_in, ah_ff, ah_in;
   logic [sra_pkg::USED_W-1:0] used_ff, used_in;
   logic [CB-1:0] init_w_ff, init_w_in, init_h_ff, init_h_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [1:0]    op_ff, op_in;
   logic [CB-1:0] w_ff, w_in, h_ff, h_in;
   logic [2*CB-1:0] prod_ff, prod_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, wc_ff, wc_in;
   logic          first_ff, first_in;
   logic [CB-1:0] y_ff, y_in, left_ff, left_in, sx_ff, sx_in, slen_ff, slen_in;
   logic          found_ff, found_in;
   logic [CW-1:0] best_i_ff, best_i_in;
   logic [CB:0]   best_top_ff, best_top_in;
   logic [CB-1:0] best_len_ff, best_len_in, best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic          tfirst_ff, tfirst_in, mhas_ff, mhas_in;
   logic [CB:0]   tend_ff, tend_in;
   sra_pkg::seg_type m_ff, m_in;
   logic          res_ok_ff, res_ok_in;
   logic [1:0]    res_st_ff, res_st_in;
   logic [CB-1:0] res_px_ff, res_px_in, res_py_ff, res_py_in;
   logic [sra_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // segment ram, two banks: the rewrite reads one and fills the other
   logic                  ram_we;
   logic [IW:0]           ram_waddr, ram_raddr;
   sra_pkg::seg_type      ram_wdata, ram_rdata;

   // scan and rewrite datapath
   logic                  feed_en, feed_pass, next_start;
   sra_pkg::seg_type      feed_seg, trim_seg, new_seg;
   logic [CB:0]           shrink;
   logic [CB+1:0]         nl, lnext;
   logic [CB-1:0]         ytop, left_cur, slen_cur, sx_cur;
   logic [CB:0]           fit_top;
   logic                  fit_fail;
   logic [sra_pkg::USED_W+1:0] used_sum;
   logic [CW-1:0]         k_prev;

   sra_ram #(
      .WIDTH ($bits(sra_pkg::seg_type)),
      .DEPTH (RAM_DEPTH)
   ) u_seg_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // roof segment of the winning placement
   assign new_seg.x   = best_x_ff;
   assign new_seg.top = CB'(best_y_ff + h_ff);
   assign new_seg.len = w_ff;

   assign used_sum = {2'b00, used_ff} + {1'b0, prod_ff};

   // old list entry that lands after the spliced roof segment
   assign k_prev = CW'(k_ff - 1'b1);

   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      count_in     = count_ff;
      aw_in        = aw_ff;
      ah_in        = ah_ff;
      used_in      = used_ff;
      init_w_in    = init_w_ff;
      init_h_in    = init_h_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      prod_in      = w_ff * h_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      wc_in        = wc_ff;
      first_in     = first_ff;
      y_in         = y_ff;
      left_in      = left_ff;
      sx_in        = sx_ff;
      slen_in      = slen_ff;
      found_in     = found_ff;
      best_i_in    = best_i_ff;
      best_top_in  = best_top_ff;
      best_len_in  = best_len_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      tfirst_in    = tfirst_ff;
      tend_in      = tend_ff;
      mhas_in      = mhas_ff;
      m_in         = m_ff;
      res_ok_in    = res_ok_ff;
      res_st_in    = res_st_ff;
      res_px_in    = res_px_ff;
      res_py_in    = res_py_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_raddr    = '0;
      feed_en      = 1'b0;
      feed_seg     = new_seg;
      next_start   = 1'b0;

      // fit step on the segment just read
      ytop     = first_ff ? ram_rdata.top
                          : ((ram_rdata.top > y_ff) ? ram_rdata.top : y_ff);
      left_cur = first_ff ? w_ff : left_ff;
      slen_cur = first_ff ? ram_rdata.len : slen_ff;
      sx_cur   = first_ff ? ram_rdata.x : sx_ff;
      lnext    = {2'b00, left_cur} - {2'b00, ram_rdata.len};
      fit_top  = {1'b0, ytop} + {1'b0, h_ff};
      fit_fail = (first_ff &&
                  (({1'b0, ram_rdata.x} + {1'b0, w_ff}) > {1'b0, aw_ff})) ||
                 (fit_top > {1'b0, ah_ff});

      // result beat leaves
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            sra_pkg::REG_INIT_WIDTH:  init_w_in = csr_wdata;
            sra_pkg::REG_INIT_HEIGHT: init_h_in = csr_wdata;
            default:                  init_w_in = init_w_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               w_in     = req_tdata[CB-1:0];
               h_in     = req_tdata[2*CB-1:CB];
               state_in = S_START;
            end
         end

         S_START: begin
            res_px_in = '0;
            res_py_in = '0;
            unique case (op_ff) inside
               sra_pkg::OP_ALLOC, sra_pkg::OP_PROBE: begin
                  found_in = 1'b0;
                  if (w_ff == '0 || count_ff == '0) begin
                     state_in = S_DECIDE;
                  end else begin
                     i_in     = '0;
                     j_in     = '0;
                     first_in = 1'b1;
                     state_in = S_FRD;
                  end
               end
               sra_pkg::OP_GROW: begin
                  if (w_ff < aw_ff || h_ff < ah_ff) begin
                     res_ok_in = 1'b0;
                     res_st_in = sra_pkg::ST_SHRINK;
                  end else if (w_ff > aw_ff && count_ff >= MAX_CNT) begin
                     res_ok_in = 1'b0;
                     res_st_in = sra_pkg::ST_FULL;
                  end else begin
                     // widening appends a floor segment on the right
                     if (w_ff > aw_ff) begin
                        ram_we        = 1'b1;
                        ram_waddr     = {bank_ff, count_ff[IW-1:0]};
                        ram_wdata.x   = aw_ff;
                        ram_wdata.top = '0;
                        ram_wdata.len = CB'(w_ff - aw_ff);
                        count_in      = CW'(count_ff + 1'b1);
                     end
                     aw_in     = w_ff;
                     ah_in     = h_ff;
                     res_ok_in = 1'b1;
                     res_st_in = sra_pkg::ST_OK;
                  end
                  state_in = S_DONE;
               end
               default: begin
                  ram_we        = 1'b1;
                  ram_waddr     = {bank_ff, {IW{1'b0}}};
                  ram_wdata.x   = '0;
                  ram_wdata.top = '0;
                  ram_wdata.len = init_w_ff;
                  count_in      = CW'(1);
                  aw_in         = init_w_ff;
                  ah_in         = init_h_ff;
                  used_in       = '0;
                  res_ok_in     = 1'b1;
                  res_st_in     = sra_pkg::ST_OK;
                  state_in      = S_DONE;
               end
            endcase
         end

         S_FRD: begin
            ram_raddr = {bank_ff, j_ff[IW-1:0]};
            state_in  = S_FUSE;
         end

         S_FUSE: begin
            first_in = 1'b0;
            y_in     = ytop;
            left_in  = lnext[CB-1:0];
            sx_in    = sx_cur;
            slen_in  = slen_cur;
            if (fit_fail) begin
               next_start = 1'b1;
            end else if (lnext[CB+1] || lnext == '0) begin
               // placement fits: lowest top wins, ties to the narrower start
               if (!found_ff || fit_top < best_top_ff ||
                   (fit_top == best_top_ff && slen_cur < best_len_ff)) begin
                  found_in    = 1'b1;
                  best_i_in   = i_ff;
                  best_top_in = fit_top;
                  best_len_in = slen_cur;
                  best_x_in   = sx_cur;
                  best_y_in   = ytop;
               end
               next_start = 1'b1;
            end else if (CW'(j_ff + 1'b1) >= count_ff) begin
               // runs past the last segment
               next_start = 1'b1;
            end else begin
               j_in     = CW'(j_ff + 1'b1);
               state_in = S_FRD;
            end
            if (next_start) begin
               if (CW'(i_ff + 1'b1) < count_ff) begin
                  i_in     = CW'(i_ff + 1'b1);
                  j_in     = CW'(i_ff + 1'b1);
                  first_in = 1'b1;
                  state_in = S_FRD;
               end else begin
                  state_in = S_DECIDE;
               end
            end
         end

         S_DECIDE: begin
            res_ok_in = 1'b0;
            state_in  = S_DONE;
            if (op_ff == sra_pkg::OP_PROBE) begin
               res_ok_in = found_ff;
               res_st_in = found_ff ? sra_pkg::ST_OK : sra_pkg::ST_NOFIT;
            end else if (!found_ff) begin
               res_st_in = sra_pkg::ST_NOFIT;
            end else if (count_ff >= MAX_CNT) begin
               res_st_in = sra_pkg::ST_FULL;
            end else begin
               k_in      = '0;
               wc_in     = '0;
               tfirst_in = 1'b1;
               mhas_in   = 1'b0;
               state_in  = S_WRD;
            end
         end

         S_WRD: begin
            // stream old list with the roof segment spliced in at best_i
            if (k_ff == CW'(count_ff + 1'b1)) begin
               state_in = S_FLUSH;
            end else if (k_ff == best_i_ff) begin
               feed_en  = 1'b1;
               feed_seg = new_seg;
               k_in     = CW'(k_ff + 1'b1);
            end else begin
               ram_raddr = {bank_ff, (k_ff < best_i_ff) ? k_ff[IW-1:0] : k_prev[IW-1:0]};
               state_in  = S_WUSE;
            end
         end

         S_WUSE: begin
            feed_en  = 1'b1;
            feed_seg = ram_rdata;
            k_in     = CW'(k_ff + 1'b1);
            state_in = S_WRD;
         end

         S_FLUSH: begin
            ram_we    = 1'b1;
            ram_waddr = {~bank_ff, wc_ff[IW-1:0]};
            ram_wdata = m_ff;
            count_in  = CW'(wc_ff + 1'b1);
            bank_in   = ~bank_ff;
            used_in   = (used_sum > {2'b00, sra_pkg::USED_MAX}) ? sra_pkg::USED_MAX
                                                             : used_sum[sra_pkg::USED_W-1:0];
            res_ok_in = 1'b1;
            res_st_in = sra_pkg::ST_OK;
            res_px_in = best_x_ff;
            res_py_in = best_y_ff;
            state_in  = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, used_ff, res_py_ff, res_px_ff, res_st_ff, res_ok_ff};
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // trim against the last kept segment, then merge equal tops
      trim_seg  = feed_seg;
      feed_pass = 1'b1;
      shrink    = tend_ff - {1'b0, feed_seg.x};
      nl        = {2'b00, feed_seg.len} - {1'b0, shrink};
      if (feed_en) begin
         if (!tfirst_ff && ({1'b0, feed_seg.x} < tend_ff)) begin
            if (nl[CB+1] || nl == '0) begin
               feed_pass = 1'b0;
            end else begin
               trim_seg.x   = tend_ff[CB-1:0];
               trim_seg.len = nl[CB-1:0];
            end
         end
         if (feed_pass) begin
            tfirst_in = 1'b0;
            tend_in   = {1'b0, trim_seg.x} + {1'b0, trim_seg.len};
            if (!mhas_ff) begin
               m_in    = trim_seg;
               mhas_in = 1'b1;
            end else if (m_ff.top == trim_seg.top) begin
               m_in.len = CB'(m_ff.len + trim_seg.len);
            end else begin
               ram_we    = 1'b1;
               ram_waddr = {~bank_ff, wc_ff[IW-1:0]};
               ram_wdata = m_ff;
               wc_in     = CW'(wc_ff + 1'b1);
               m_in      = trim_seg;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bank_ff      <= 1'b0;
         count_ff     <= '0;
         aw_ff        <= '0;
         ah_ff        <= '0;
         used_ff      <= '0;
         init_w_ff    <= CB'(1024);
         init_h_ff    <= CB'(1024);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         count_ff     <= count_in;
         aw_ff        <= aw_in;
         ah_ff        <= ah_in;
         used_ff      <= used_in;
         init_w_ff    <= init_w_in;
         init_h_ff    <= init_h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      prod_ff     <= prod_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      wc_ff       <= wc_in;
      first_ff    <= first_in;
      y_ff        <= y_in;
      left_ff     <= left_in;
      sx_ff       <= sx_in;
      slen_ff     <= slen_in;
      found_ff    <= found_in;
      best_i_ff   <= best_i_in;
      best_top_ff <= best_top_in;
      best_len_ff <= best_len_in;
      best_x_ff   <= best_x_in;
      best_y_ff   <= best_y_in;
      tfirst_ff   <= tfirst_in;
      tend_ff     <= tend_in;
      mhas_ff     <= mhas_in;
      m_ff        <= m_in;
      res_ok_ff   <= res_ok_in;
      res_st_ff   <= res_st_in;
      res_px_ff   <= res_px_in;
      res_py_ff   <= res_py_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: dv/tb_top.sv
// self-checking testbench for the skyline rectangle allocator
`timescale 1ns / 1ps
module tb_top;

   // one expected response beat
   typedef struct {
      logic                       ok;
      logic [1:0]                 status;
      logic [sra_pkg::CB-1:0]     pos_x;
      logic [sra_pkg::CB-1:0]     pos_y;
      logic [sra_pkg::USED_W-1:0] used;
   } rsp_fields_type;

   // shadow skyline and the queue of responses it predicts
   class skyline_board_type;
      int unsigned sx[sra_pkg::MAX_SEG_DEF], stop[sra_pkg::MAX_SEG_DEF];
      int unsigned slen[sra_pkg::MAX_SEG_DEF];
      int unsigned nseg, area_w, area_h, used, cfg_w, cfg_h;
      rsp_fields_type awaited[$];
      int          mismatches, checked, placed, full_hits;

      function new();
         cfg_w = 1024;
         cfg_h = 1024;
      endfunction

      function void write_reg(logic index, int unsigned value);
         if (index == sra_pkg::REG_INIT_WIDTH) cfg_w = value & 13'h1fff;
         else cfg_h = value & 13'h1fff;
      endfunction

      // bottom y of a w x h rectangle started at segment s, -1 if it does not fit
      function int fit_at(int unsigned s, int unsigned w, int unsigned h);
         int unsigned j, y;
         int          left;
         j = s;
         left = w;
         if (sx[s] + w > area_w) return -1;
         y = stop[s];
         while (left > 0) begin
            if (j >= nseg) return -1;
            if (stop[j] > y) y = stop[j];
            if (y + h > area_h) return -1;
            left -= slen[j];
            j++;
         end
         return y;
      endfunction

      function bit best_spot(int unsigned w, int unsigned h,
                             output int unsigned bi, output int unsigned by);
         bit          found;
         int unsigned top_best, len_best;
         int          y;
         found = 0;
         top_best = 0;
         len_best = 0;
         bi = 0;
         by = 0;
         if (w == 0) return 0;
         for (int unsigned i = 0; i < nseg; i++) begin
            y = fit_at(i, w, h);
            if (y < 0) continue;
            if (!found || y + h < top_best ||
                (y + h == top_best && slen[i] < len_best)) begin
               found = 1;
               top_best = y + h;
               len_best = slen[i];
               bi = i;
               by = y;
            end
         end
         return found;
      endfunction

      function void drop_seg(int unsigned i);
         for (int unsigned k = i; k + 1 < nseg; k++) begin
            sx[k] = sx[k+1];
            stop[k] = stop[k+1];
            slen[k] = slen[k+1];
         end
         nseg--;
      endfunction

      function void add_seg(int unsigned i, int unsigned x, int unsigned t, int unsigned l);
         for (int unsigned k = nseg; k > i; k--) begin
            sx[k] = sx[k-1];
            stop[k] = stop[k-1];
            slen[k] = slen[k-1];
         end
         sx[i] = x;
         stop[i] = t;
         slen[i] = l;
         nseg++;
      endfunction

      function void tidy_roof();
         int unsigned i, e;
         int          nl;
         i = 1;
         while (i < nseg) begin
            e = sx[i-1] + slen[i-1];
            if (sx[i] < e) begin
               nl = int'(slen[i]) - int'(e - sx[i]);
               if (nl <= 0) begin
                  drop_seg(i);
                  continue;
               end
               sx[i] = e & 13'h1fff;
               slen[i] = nl;
            end
            i++;
         end
         i = 1;
         while (i < nseg) begin
            if (stop[i-1] == stop[i]) begin
               slen[i-1] = (slen[i-1] + slen[i]) & 13'h1fff;
               drop_seg(i);
               continue;
            end
            i++;
         end
      endfunction

      // accepted request beat: update the shadow and queue the response
      function void note_request(logic [1:0] op, int unsigned w, int unsigned h);
         rsp_fields_type r;
         int unsigned bi, by;
         longint      sum;
         r = '{1'b0, sra_pkg::ST_OK, '0, '0, '0};
         if (op == sra_pkg::OP_ALLOC) begin
            if (!best_spot(w, h, bi, by)) r.status = sra_pkg::ST_NOFIT;
            else if (nseg >= sra_pkg::MAX_SEG_DEF) begin
               r.status = sra_pkg::ST_FULL;
               full_hits++;
            end else begin
               r.pos_x = sx[bi];
               r.pos_y = by;
               add_seg(bi, sx[bi], (by + h) & 13'h1fff, w);
               tidy_roof();
               sum = longint'(used) + longint'(w) * h;
               used = (sum > sra_pkg::USED_MAX) ? sra_pkg::USED_MAX : sum;
               r.ok = 1;
               placed++;
            end
         end else if (op == sra_pkg::OP_PROBE) begin
            if (best_spot(w, h, bi, by)) r.ok = 1;
            else r.status = sra_pkg::ST_NOFIT;
         end else if (op == sra_pkg::OP_GROW) begin
            if (w < area_w || h < area_h) r.status = sra_pkg::ST_SHRINK;
            else if (w > area_w && nseg >= sra_pkg::MAX_SEG_DEF) begin
               r.status = sra_pkg::ST_FULL;
               full_hits++;
            end else begin
               if (w > area_w) add_seg(nseg, area_w, 0, w - area_w);
               area_w = w;
               area_h = h;
               r.ok = 1;
            end
         end else begin
            nseg = 0;
            add_seg(0, 0, 0, cfg_w);
            area_w = cfg_w;
            area_h = cfg_h;
            used = 0;
            r.ok = 1;
         end
         r.used = used;
         awaited = {awaited, r};
      endfunction

      // accepted response beat: compare with the oldest prediction
      function void check_response(logic [sra_pkg::RSP_DATA_W-1:0] d);
         rsp_fields_type e, a;
         a.ok = d[0];
         a.status = d[2:1];
         a.pos_x = d[15:3];
         a.pos_y = d[28:16];
         a.used = d[53:29];
         checked++;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %h", d);
            return;
         end
         e = awaited.pop_front();
         if (a.ok !== e.ok || a.status !== e.status || a.pos_x !== e.pos_x ||
             a.pos_y !== e.pos_y || a.used !== e.used) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: exp ok=%0d st=%0d x=%0d y=%0d used=%0d,",
                         " got ok=%0d st=%0d x=%0d y=%0d used=%0d"},
                        e.ok, e.status, e.pos_x, e.pos_y, e.used,
                        a.ok, a.status, a.pos_x, a.pos_y, a.used);
         end
      endfunction
   endclass

   logic                           clock, reset;
   logic                           req_tvalid, req_tready;
   logic [sra_pkg::REQ_DATA_W-1:0] req_tdata;  // width, height
   logic [1:0]                     req_tuser;  // op
   logic                           rsp_tvalid, rsp_tready;
   logic [sra_pkg::RSP_DATA_W-1:0] rsp_tdata;  // ok, status, pos_x, pos_y, used_area
   logic                           csr_we, csr_index;
   logic [sra_pkg::CB-1:0]         csr_wdata;

   skyline_board_type board;
   int           send_gap_pct, rsp_stall_pct, stuck_cycles, item_count;

   localparam int STUCK_LIMIT = 400000;

   skyline_rect_allocator_unit u_top (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // response side: random back-pressure, checking and the watchdog
   always @(posedge clock) begin
      if (reset) begin
         stuck_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) stuck_cycles <= 0;
         else stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STUCK_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic send_beat(logic [1:0] op, int unsigned w, int unsigned h);
      // optional gap before the beat, valid dropped only if a gap is taken
      if ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'd0, h[sra_pkg::CB-1:0], w[sra_pkg::CB-1:0]};
      do @(posedge clock); while (!req_tready);
      board.note_request(op, w & 13'h1fff, h & 13'h1fff);
      item_count++;
   endtask

   // wait until every predicted response has been seen
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.awaited.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic index, int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[sra_pkg::CB-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      board.write_reg(index, value);
      @(posedge clock);
   endtask

   // mostly allocations of modest size so the skyline gets busy
   task automatic random_beat();
      int unsigned sel, w, h, aw, ah;
      sel = $urandom_range(99);
      aw = (board.area_w < 16) ? 16 : board.area_w;
      ah = (board.area_h < 16) ? 16 : board.area_h;
      if (sel < 5) begin
         send_beat(2'($urandom_range(3)), $urandom_range(8191), $urandom_range(8191));
      end else if (sel < 78) begin
         w = $urandom_range(aw / 10 + 1, 1);
         h = $urandom_range(ah / 12 + 1, 1);
         send_beat(sra_pkg::OP_ALLOC, w, h);
      end else if (sel < 90) begin
         send_beat(sra_pkg::OP_PROBE, $urandom_range(aw / 3, 0), $urandom_range(ah / 3, 0));
      end else if (sel < 97) begin
         // mostly legal growth, sometimes a shrink attempt
         w = board.area_w + (($urandom_range(3) == 0) ? 0 : $urandom_range(40));
         h = board.area_h + $urandom_range(200);
         if ($urandom_range(5) == 0) w = $urandom_range(board.area_w);
         send_beat(sra_pkg::OP_GROW, w & 13'h1fff, h & 13'h1fff);
      end else begin
         send_beat(sra_pkg::OP_CLEAR, $urandom_range(8191), $urandom_range(8191));
      end
   endtask

   task automatic random_phase(int unsigned cw, int unsigned ch, int gap, int stall, int n);
      drain();
      write_csr(sra_pkg::REG_INIT_WIDTH, cw);
      write_csr(sra_pkg::REG_INIT_HEIGHT, ch);
      send_gap_pct = gap;
      rsp_stall_pct = stall;
      send_beat(sra_pkg::OP_CLEAR, 0, 0);
      repeat (n) random_beat();
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = sra_pkg::OP_ALLOC;
      csr_we = 1'b0;
      csr_index = sra_pkg::REG_INIT_WIDTH;
      csr_wdata = '0;
      item_count = 0;
      send_gap_pct = 15;
      rsp_stall_pct = 61;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty store before any clear
      send_beat(sra_pkg::OP_ALLOC, 4, 4);
      send_beat(sra_pkg::OP_PROBE, 1, 1);
      send_beat(sra_pkg::OP_GROW, 0, 0);
      send_beat(sra_pkg::OP_GROW, 8, 8);
      send_beat(sra_pkg::OP_ALLOC, 8, 8);
      // largest area: full-size rectangle, usage saturates
      drain();
      write_csr(sra_pkg::REG_INIT_WIDTH, 8191);
      write_csr(sra_pkg::REG_INIT_HEIGHT, 8191);
      send_beat(sra_pkg::OP_CLEAR, 0, 0);
      send_beat(sra_pkg::OP_ALLOC, 0, 5);
      send_beat(sra_pkg::OP_PROBE, 8191, 8191);
      send_beat(sra_pkg::OP_ALLOC, 8191, 8191);
      send_beat(sra_pkg::OP_ALLOC, 1, 1);
      send_beat(sra_pkg::OP_GROW, 100, 8191);
      // zero-size area, then widen it
      drain();
      write_csr(sra_pkg::REG_INIT_WIDTH, 0);
      write_csr(sra_pkg::REG_INIT_HEIGHT, 0);
      send_beat(sra_pkg::OP_CLEAR, 0, 0);
      send_beat(sra_pkg::OP_ALLOC, 1, 0);
      send_beat(sra_pkg::OP_GROW, 0, 50);
      send_beat(sra_pkg::OP_GROW, 30, 50);
      send_beat(sra_pkg::OP_ALLOC, 10, 50);
      send_beat(sra_pkg::OP_ALLOC, 20, 51);
      send_beat(sra_pkg::OP_ALLOC, 30, 0);
      send_beat(sra_pkg::OP_PROBE, 20, 0);
      send_beat(sra_pkg::OP_GROW, 29, 60);

      // random phases with the idling patterns; the narrow area fills the store
      random_phase(96, 4095, 15, 61, 330);
      random_phase(512, 512, 61, 15, 330);
      random_phase(4096, 4096, 0, 0, 340);
      drain();

      $display("%0d request beats, %0d responses checked",
               item_count, board.checked);
      $display("%0d placements, %0d store-full answers", board.placed, board.full_hits);
      if (board.mismatches == 0 && board.awaited.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
